FILE: hdl/cvmb_pkg.sv
// ----------------------------------------------------------------------------
// cvmb_pkg
// Shared types and constants of the cell voltage monitor and balancer.
// ----------------------------------------------------------------------------
package cvmb_pkg;

    localparam int CELL_W    = 16;
    localparam int SUM_W     = 22;
    localparam int IDX_W     = 7;
    localparam int STREAK_W  = 8;
    localparam int THR_W     = 17;
    localparam int NUM_W     = 6;
    localparam int CUR_W     = 19;

    localparam logic [THR_W-1:0]    DC_OFFSET   = 17'd500;
    localparam logic [THR_W-1:0]    MARGIN_HIGH = 17'd20;
    localparam logic [THR_W-1:0]    MARGIN_MID  = 17'd50;
    localparam logic [THR_W-1:0]    MARGIN_LOW  = 17'd100;
    localparam logic [STREAK_W-1:0] STREAK_MAX  = 8'd255;
    localparam logic signed [CUR_W-1:0] CURRENT_LIMIT_MA = 19'sd7000;

    // register map, word index
    typedef enum logic [2:0] {
        REG_OV_LIMIT  = 3'd0,
        REG_UV_LIMIT  = 3'd1,
        REG_IMB_LIMIT = 3'd2,
        REG_BAL_UPPER = 3'd3,
        REG_BAL_LOWER = 3'd4,
        REG_SOLAR     = 3'd5,
        REG_DEBOUNCE  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [CELL_W-1:0]   ov_limit;
        logic [CELL_W-1:0]   uv_limit;
        logic [CELL_W-1:0]   imb_limit;
        logic [CELL_W-1:0]   bal_upper;
        logic [CELL_W-1:0]   bal_lower;
        logic [CELL_W-1:0]   solar_limit;
        logic [STREAK_W-1:0] debounce;
    } cfg_t;

    // everything the back end needs to emit one closed scan
    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [CELL_W-1:0] max_v;
        logic [CELL_W-1:0] min_v;
        logic [IDX_W-1:0]  max_idx;
        logic [IDX_W-1:0]  min_idx;
        logic [IDX_W-1:0]  count;
        logic [THR_W-1:0]  thr;
        logic              ov;
        logic              uv;
        logic              imb;
        logic              solar;
        logic              allow;
    } scan_desc_t;

endpackage

FILE: hdl/cvmb_ram.sv
// ----------------------------------------------------------------------------
// cvmb_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cvmb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 72
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/cvmb_front.sv
// ----------------------------------------------------------------------------
// cvmb_front
// Accepts cell items, offsets and stores them, tracks scan statistics and
// closes each scan into a descriptor for the back end.
// ----------------------------------------------------------------------------
module cvmb_front #(
    parameter int CELL_SLOTS = 36
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cvmb_pkg::cfg_t                       cfg,
    input  logic                                 cell_valid,
    output logic                                 cell_ready,
    input  logic [cvmb_pkg::CELL_W-1:0]          cell_reading,
    input  logic                                 last_cell,
    input  logic                                 balance_request,
    input  logic signed [cvmb_pkg::CUR_W-1:0]    pack_current_ma,
    input  logic                                 protection_bypassed,
    input  logic                                 q_full,
    input  logic                                 wr_bank,
    output logic                                 push,
    output cvmb_pkg::scan_desc_t                 push_desc,
    output logic                                 ram_we,
    output logic [$clog2(2*CELL_SLOTS)-1:0]      ram_waddr,
    output logic [cvmb_pkg::CELL_W-1:0]          ram_wdata
);

    localparam int CNT_W = $clog2(CELL_SLOTS + 1);
    localparam int AW    = $clog2(2 * CELL_SLOTS);

    logic [cvmb_pkg::SUM_W-1:0]    sum_reg;
    logic [cvmb_pkg::CELL_W-1:0]   max_reg;
    logic [cvmb_pkg::CELL_W-1:0]   min_reg;
    logic [cvmb_pkg::IDX_W-1:0]    max_idx_reg;
    logic [cvmb_pkg::IDX_W-1:0]    min_idx_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          close_reg;
    logic                          allow_reg;
    logic                          bypass_reg;
    logic [cvmb_pkg::STREAK_W-1:0] ov_streak_reg;
    logic [cvmb_pkg::STREAK_W-1:0] uv_streak_reg;

    logic                          accept;
    logic                          take;
    logic [cvmb_pkg::THR_W-1:0]    raw_sum;
    logic [cvmb_pkg::CELL_W-1:0]   v;
    logic [cvmb_pkg::IDX_W-1:0]    idx_one;
    logic                          ov_cond;
    logic                          uv_cond;
    logic [cvmb_pkg::STREAK_W-1:0] ov_streak_next;
    logic [cvmb_pkg::STREAK_W-1:0] uv_streak_next;
    logic [cvmb_pkg::THR_W-1:0]    margin;

    assign cell_ready = !close_reg && !q_full;
    assign accept     = cell_valid && cell_ready;
    // cells past the store depth are dropped, their last bit still counts
    assign take       = accept && (cnt_reg < CNT_W'(CELL_SLOTS));

    assign raw_sum = {1'b0, cell_reading} + cvmb_pkg::DC_OFFSET;
    assign v       = raw_sum[cvmb_pkg::CELL_W] ? '1 : raw_sum[cvmb_pkg::CELL_W-1:0];
    assign idx_one = cvmb_pkg::IDX_W'(cnt_reg) + 7'd1;

    assign ram_we    = take;
    assign ram_waddr = (wr_bank ? AW'(CELL_SLOTS) : AW'(0)) + AW'(cnt_reg);
    assign ram_wdata = v;

    // scan close checks, evaluated on the settled accumulators
    always_comb
    begin
        ov_cond = max_reg >= cfg.ov_limit;
        uv_cond = min_reg <= cfg.uv_limit;
        ov_streak_next = '0;
        uv_streak_next = '0;
        if (ov_cond)
        begin
            ov_streak_next = (ov_streak_reg == cvmb_pkg::STREAK_MAX) ?
                             cvmb_pkg::STREAK_MAX : ov_streak_reg + 8'd1;
        end
        if (uv_cond)
        begin
            uv_streak_next = (uv_streak_reg == cvmb_pkg::STREAK_MAX) ?
                             cvmb_pkg::STREAK_MAX : uv_streak_reg + 8'd1;
        end
        if (min_reg >= cfg.bal_upper)
        begin
            margin = cvmb_pkg::MARGIN_HIGH;
        end
        else if (min_reg >= cfg.bal_lower)
        begin
            margin = cvmb_pkg::MARGIN_MID;
        end
        else
        begin
            margin = cvmb_pkg::MARGIN_LOW;
        end

        push_desc.sum     = sum_reg;
        push_desc.max_v   = max_reg;
        push_desc.min_v   = min_reg;
        push_desc.max_idx = max_idx_reg;
        push_desc.min_idx = min_idx_reg;
        push_desc.count   = cvmb_pkg::IDX_W'(cnt_reg);
        push_desc.thr     = {1'b0, min_reg} + margin;
        push_desc.ov      = ov_cond && (ov_streak_next >= cfg.debounce);
        push_desc.uv      = uv_cond && (uv_streak_next >= cfg.debounce);
        push_desc.imb     = (max_reg >= min_reg) && ((max_reg - min_reg) >= cfg.imb_limit);
        push_desc.solar   = (max_reg >= cfg.solar_limit) && !bypass_reg;
        push_desc.allow   = allow_reg;
    end

    assign push = close_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            max_reg       <= '0;
            min_reg       <= '1;
            max_idx_reg   <= '0;
            min_idx_reg   <= '0;
            cnt_reg       <= '0;
            close_reg     <= 1'b0;
            allow_reg     <= 1'b0;
            bypass_reg    <= 1'b0;
            ov_streak_reg <= '0;
            uv_streak_reg <= '0;
        end
        else if (close_reg)
        begin
            sum_reg       <= '0;
            max_reg       <= '0;
            min_reg       <= '1;
            max_idx_reg   <= '0;
            min_idx_reg   <= '0;
            cnt_reg       <= '0;
            close_reg     <= 1'b0;
            ov_streak_reg <= ov_streak_next;
            uv_streak_reg <= uv_streak_next;
        end
        else
        begin
            if (take)
            begin
                sum_reg <= sum_reg + cvmb_pkg::SUM_W'(v);
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (v > max_reg)
                begin
                    max_reg     <= v;
                    max_idx_reg <= idx_one;
                end
                if (v < min_reg)
                begin
                    min_reg     <= v;
                    min_idx_reg <= idx_one;
                end
            end
            if (accept && last_cell)
            begin
                close_reg  <= 1'b1;
                allow_reg  <= balance_request && (pack_current_ma <= cvmb_pkg::CURRENT_LIMIT_MA);
                bypass_reg <= protection_bypassed;
            end
        end
    end

endmodule

FILE: hdl/cvmb_scan_queue.sv
// ----------------------------------------------------------------------------
// cvmb_scan_queue
// Two-entry queue of closed scan descriptors; entry i owns store bank i.
// ----------------------------------------------------------------------------
module cvmb_scan_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  cvmb_pkg::scan_desc_t push_desc,
    input  logic                 pop,
    output cvmb_pkg::scan_desc_t head,
    output logic                 full,
    output logic                 empty,
    output logic                 wr_ptr,
    output logic                 rd_ptr
);

    cvmb_pkg::scan_desc_t desc_reg [2];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           cnt_reg;

    assign full   = cnt_reg == 2'd2;
    assign empty  = cnt_reg == 2'd0;
    assign wr_ptr = wr_ptr_reg;
    assign rd_ptr = rd_ptr_reg;
    assign head   = desc_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            desc_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

FILE: hdl/cvmb_back.sv
// ----------------------------------------------------------------------------
// cvmb_back
// Walks the stored cells of the head scan and emits one result item per cell.
// ----------------------------------------------------------------------------
module cvmb_back #(
    parameter int CELL_SLOTS = 36
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_empty,
    input  cvmb_pkg::scan_desc_t             head,
    input  logic                             rd_bank,
    output logic                             pop,
    output logic                             ram_re,
    output logic [$clog2(2*CELL_SLOTS)-1:0]  ram_raddr,
    input  logic [cvmb_pkg::CELL_W-1:0]      ram_rdata,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [cvmb_pkg::NUM_W-1:0]       cell_number,
    output logic                             discharge_on,
    output logic                             last_result
);

    localparam int CNT_W = $clog2(CELL_SLOTS + 1);
    localparam int AW    = $clog2(2 * CELL_SLOTS);

    logic [CNT_W-1:0]           k_reg;
    logic                       s1_vld_reg;
    logic [CNT_W-1:0]           s1_idx_reg;
    logic                       s1_last_reg;
    logic                       out_vld_reg;
    logic [cvmb_pkg::NUM_W-1:0] out_num_reg;
    logic                       out_dis_reg;
    logic                       out_last_reg;

    logic                       more;
    logic                       s1_move;
    logic                       issue;
    logic                       bleed;

    assign more    = !q_empty && (k_reg < CNT_W'(head.count));
    assign s1_move = s1_vld_reg && (!out_vld_reg || result_ready);
    assign issue   = more && (!s1_vld_reg || s1_move);
    assign bleed   = head.allow && ({1'b0, ram_rdata} > head.thr);

    assign ram_re    = issue;
    assign ram_raddr = (rd_bank ? AW'(CELL_SLOTS) : AW'(0)) + AW'(k_reg);

    // the head entry retires once its final item is taken
    assign pop = out_vld_reg && result_ready && out_last_reg;

    assign result_valid = out_vld_reg;
    assign cell_number  = out_num_reg;
    assign discharge_on = out_dis_reg;
    assign last_result  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg       <= '0;
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                k_reg <= '0;
            end
            else if (issue)
            begin
                k_reg <= k_reg + CNT_W'(1);
            end
            if (issue)
            begin
                s1_vld_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_vld_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_idx_reg  <= k_reg;
            s1_last_reg <= (k_reg + CNT_W'(1)) == CNT_W'(head.count);
        end
        if (s1_move)
        begin
            out_num_reg  <= cvmb_pkg::NUM_W'(s1_idx_reg);
            out_dis_reg  <= bleed;
            out_last_reg <= s1_last_reg;
        end
    end

endmodule

FILE: hdl/cell_voltage_monitor_balancer.sv
// ----------------------------------------------------------------------------
// cell_voltage_monitor_balancer
// Cell voltage scan monitor with debounced voltage faults and balancing.
// ----------------------------------------------------------------------------
// One cell reading per item; each gets +500 (saturating) and goes into a
// two-bank cell store while the front end keeps the scan sum, max and min.
// An item with last_cell closes the scan: a closing state then evaluates the
// fault, imbalance, solar and balance checks and queues a scan descriptor.
// The back end then emits one result item per stored cell, one per cycle
// while result_ready is high, from the store read port through a read stage
// and an output register. Input items are taken one per cycle except in the
// closing cycle and while both store banks hold scans still waiting to be
// emitted, so a scan can be filled while the previous one drains.
// ----------------------------------------------------------------------------
module cell_voltage_monitor_balancer #(
    parameter int CELL_SLOTS = 36
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // config port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // cell items
    input  logic                 cell_valid,
    output logic                 cell_ready,
    input  logic [15:0]          cell_reading,
    input  logic                 last_cell,
    input  logic                 balance_request,
    input  logic signed [18:0]   pack_current_ma,
    input  logic                 protection_bypassed,
    // result items
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [5:0]           cell_number,
    output logic                 discharge_on,
    output logic [21:0]          pack_sum,
    output logic [15:0]          highest_voltage,
    output logic [15:0]          lowest_voltage,
    output logic [6:0]           highest_cell,
    output logic [6:0]           lowest_cell,
    output logic                 overvoltage_fault,
    output logic                 undervoltage_fault,
    output logic                 imbalance_flag,
    output logic                 open_solar,
    output logic                 last_result
);

    localparam int AW = $clog2(2 * CELL_SLOTS);

    cvmb_pkg::cfg_t       cfg_reg;
    cvmb_pkg::reg_idx_t   reg_sel;
    logic                 cfg_write;

    logic                 push;
    cvmb_pkg::scan_desc_t push_desc;
    logic                 pop;
    cvmb_pkg::scan_desc_t head;
    logic                 q_full;
    logic                 q_empty;
    logic                 wr_ptr;
    logic                 rd_ptr;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [15:0]          ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [15:0]          ram_rdata;

    // register file, word addressed
    assign pready    = 1'b1;
    assign reg_sel   = cvmb_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ov_limit    <= 16'd42500;
            cfg_reg.uv_limit    <= 16'd25000;
            cfg_reg.imb_limit   <= 16'd1000;
            cfg_reg.bal_upper   <= 16'd41500;
            cfg_reg.bal_lower   <= 16'd40000;
            cfg_reg.solar_limit <= 16'd41000;
            cfg_reg.debounce    <= 8'd1;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                cvmb_pkg::REG_OV_LIMIT:  cfg_reg.ov_limit    <= pwdata[15:0];
                cvmb_pkg::REG_UV_LIMIT:  cfg_reg.uv_limit    <= pwdata[15:0];
                cvmb_pkg::REG_IMB_LIMIT: cfg_reg.imb_limit   <= pwdata[15:0];
                cvmb_pkg::REG_BAL_UPPER: cfg_reg.bal_upper   <= pwdata[15:0];
                cvmb_pkg::REG_BAL_LOWER: cfg_reg.bal_lower   <= pwdata[15:0];
                cvmb_pkg::REG_SOLAR:     cfg_reg.solar_limit <= pwdata[15:0];
                cvmb_pkg::REG_DEBOUNCE:  cfg_reg.debounce    <= pwdata[7:0];
                default:
                begin
                    // unmapped word, write ignored
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            cvmb_pkg::REG_OV_LIMIT:  prdata = {16'd0, cfg_reg.ov_limit};
            cvmb_pkg::REG_UV_LIMIT:  prdata = {16'd0, cfg_reg.uv_limit};
            cvmb_pkg::REG_IMB_LIMIT: prdata = {16'd0, cfg_reg.imb_limit};
            cvmb_pkg::REG_BAL_UPPER: prdata = {16'd0, cfg_reg.bal_upper};
            cvmb_pkg::REG_BAL_LOWER: prdata = {16'd0, cfg_reg.bal_lower};
            cvmb_pkg::REG_SOLAR:     prdata = {16'd0, cfg_reg.solar_limit};
            cvmb_pkg::REG_DEBOUNCE:  prdata = {24'd0, cfg_reg.debounce};
            default:                 prdata = '0;
        endcase
    end

    // front end: accept, offset, store, accumulate, close scan
    cvmb_front #(
        .CELL_SLOTS (CELL_SLOTS)
    ) u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg                 (cfg_reg),
        .cell_valid          (cell_valid),
        .cell_ready          (cell_ready),
        .cell_reading        (cell_reading),
        .last_cell           (last_cell),
        .balance_request     (balance_request),
        .pack_current_ma     (pack_current_ma),
        .protection_bypassed (protection_bypassed),
        .q_full              (q_full),
        .wr_bank             (wr_ptr),
        .push                (push),
        .push_desc           (push_desc),
        .ram_we              (ram_we),
        .ram_waddr           (ram_waddr),
        .ram_wdata           (ram_wdata)
    );

    // closed scans waiting for the back end, one store bank each
    cvmb_scan_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty),
        .wr_ptr    (wr_ptr),
        .rd_ptr    (rd_ptr)
    );

    // cell store, two banks of CELL_SLOTS entries
    cvmb_ram #(
        .WIDTH (16),
        .DEPTH (2 * CELL_SLOTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // back end: per-cell result items
    cvmb_back #(
        .CELL_SLOTS (CELL_SLOTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .head         (head),
        .rd_bank      (rd_ptr),
        .pop          (pop),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cell_number  (cell_number),
        .discharge_on (discharge_on),
        .last_result  (last_result)
    );

    // scan-wide fields come straight from the head descriptor
    assign pack_sum           = head.sum;
    assign highest_voltage    = head.max_v;
    assign lowest_voltage     = head.min_v;
    assign highest_cell       = head.max_idx;
    assign lowest_cell        = head.min_idx;
    assign overvoltage_fault  = head.ov;
    assign undervoltage_fault = head.uv;
    assign imbalance_flag     = head.imb;
    assign open_solar         = head.solar;

    // a scan is never queued when both banks are taken
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("scan descriptor pushed into a full queue");

    // the front end never writes the bank the back end is draining
    a_bank_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && !q_empty) |-> (wr_ptr != rd_ptr))
        else $error("cell store write hits the bank being emitted");

    // a result item always has a scan descriptor behind it
    a_result_has_scan: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !q_empty)
        else $error("result item without a queued scan");

endmodule

FILE: dv/tb_cell_voltage_monitor_balancer.sv
// ----------------------------------------------------------------------------
// tb_cell_voltage_monitor_balancer
// Self-checking bench for the cell voltage monitor and balancer.
// ----------------------------------------------------------------------------
// Cell items go in over a valid/ready channel and result items come back over
// another. A scoreboard class predicts every result of a closed scan when the
// closing item is accepted, and compares each result, field by field, with the
// oldest expectation. Register settings move through reset values, mid values,
// all zeros and all ones, plus a run of faulty scans and a run at a short
// debounce for the streak counters. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_cell_voltage_monitor_balancer;

    localparam int MAX_CELLS      = 36;
    localparam int READING_OFFSET = 500;
    localparam int BLEED_NARROW   = 20;
    localparam int BLEED_MID      = 50;
    localparam int BLEED_WIDE     = 100;
    localparam int CURRENT_CAP_MA = 7000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 400;
    localparam int LIMIT_CYCLES   = 200000;

    // one cell item as offered to the block
    typedef struct packed {
        logic [cvmb_pkg::CELL_W-1:0]       raw;
        logic                              last;
        logic                              request;
        logic signed [cvmb_pkg::CUR_W-1:0] current;
        logic                              bypass;
    } cell_item_t;

    // one result item, in port order
    typedef struct packed {
        logic [cvmb_pkg::NUM_W-1:0]  cell_num;
        logic                        bleed;
        logic [cvmb_pkg::SUM_W-1:0]  sum;
        logic [cvmb_pkg::CELL_W-1:0] vmax;
        logic [cvmb_pkg::CELL_W-1:0] vmin;
        logic [cvmb_pkg::IDX_W-1:0]  max_cell;
        logic [cvmb_pkg::IDX_W-1:0]  min_cell;
        logic                        ov;
        logic                        uv;
        logic                        imb;
        logic                        solar;
        logic                        last_one;
    } result_t;

    // ------------------------------------------------------------------------
    // scan predictor and result checker
    // ------------------------------------------------------------------------
    class scan_scoreboard;
        cvmb_pkg::cfg_t                cfg;
        logic [cvmb_pkg::CELL_W-1:0]   stored [MAX_CELLS];
        logic [cvmb_pkg::SUM_W-1:0]    sum;
        logic [cvmb_pkg::CELL_W-1:0]   vmax;
        logic [cvmb_pkg::CELL_W-1:0]   vmin;
        logic [cvmb_pkg::IDX_W-1:0]    max_cell;
        logic [cvmb_pkg::IDX_W-1:0]    min_cell;
        int unsigned                   count;
        logic [cvmb_pkg::STREAK_W-1:0] ov_streak;
        logic [cvmb_pkg::STREAK_W-1:0] uv_streak;
        result_t                       expected_q [$];
        int unsigned                   mismatches;
        int unsigned                   checked;
        int unsigned                   cells_in;
        int unsigned                   scans;
        int unsigned                   bled;

        function void power_on();
            cfg.ov_limit    = 16'd42500;
            cfg.uv_limit    = 16'd25000;
            cfg.imb_limit   = 16'd1000;
            cfg.bal_upper   = 16'd41500;
            cfg.bal_lower   = 16'd40000;
            cfg.solar_limit = 16'd41000;
            cfg.debounce    = 8'd1;
            ov_streak = '0;
            uv_streak = '0;
            open_scan();
        endfunction

        function void open_scan();
            sum      = '0;
            vmax     = '0;
            vmin     = '1;
            max_cell = '0;
            min_cell = '0;
            count    = 0;
        endfunction

        function void set_reg(cvmb_pkg::reg_idx_t idx, logic [31:0] d);
            case (idx)
                cvmb_pkg::REG_OV_LIMIT:  cfg.ov_limit    = d[15:0];
                cvmb_pkg::REG_UV_LIMIT:  cfg.uv_limit    = d[15:0];
                cvmb_pkg::REG_IMB_LIMIT: cfg.imb_limit   = d[15:0];
                cvmb_pkg::REG_BAL_UPPER: cfg.bal_upper   = d[15:0];
                cvmb_pkg::REG_BAL_LOWER: cfg.bal_lower   = d[15:0];
                cvmb_pkg::REG_SOLAR:     cfg.solar_limit = d[15:0];
                cvmb_pkg::REG_DEBOUNCE:  cfg.debounce    = d[7:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // accepted cell item: update the scan and, on the closing item,
        // queue one expected result per stored cell
        function void note_cell(cell_item_t it);
            logic [cvmb_pkg::THR_W-1:0] v;
            logic [cvmb_pkg::THR_W-1:0] thr;
            logic                       ov, uv, imb, solar, allow;
            result_t                    r;
            cells_in++;
            if (count < MAX_CELLS)
            begin
                v = {1'b0, it.raw} + cvmb_pkg::THR_W'(READING_OFFSET);
                if (v > 17'h0FFFF)
                    v = 17'h0FFFF;
                stored[count] = v[cvmb_pkg::CELL_W-1:0];
                sum = sum + cvmb_pkg::SUM_W'(v);
                if (v[cvmb_pkg::CELL_W-1:0] > vmax)
                begin
                    vmax     = v[cvmb_pkg::CELL_W-1:0];
                    max_cell = cvmb_pkg::IDX_W'(count + 1);
                end
                if (v[cvmb_pkg::CELL_W-1:0] < vmin)
                begin
                    vmin     = v[cvmb_pkg::CELL_W-1:0];
                    min_cell = cvmb_pkg::IDX_W'(count + 1);
                end
                count++;
            end
            if (!it.last)
                return;
            scans++;
            ov = vmax >= cfg.ov_limit;
            if (ov)
            begin
                if (ov_streak != '1)
                    ov_streak++;
                ov = ov_streak >= cfg.debounce;
            end
            else
            begin
                ov_streak = '0;
            end
            uv = vmin <= cfg.uv_limit;
            if (uv)
            begin
                if (uv_streak != '1)
                    uv_streak++;
                uv = uv_streak >= cfg.debounce;
            end
            else
            begin
                uv_streak = '0;
            end
            imb   = (vmax >= vmin) && ((vmax - vmin) >= cfg.imb_limit);
            solar = (vmax >= cfg.solar_limit) && !it.bypass;
            allow = it.request && ($signed(it.current) <= CURRENT_CAP_MA);
            if (vmin >= cfg.bal_upper)
                thr = {1'b0, vmin} + cvmb_pkg::THR_W'(BLEED_NARROW);
            else if (vmin >= cfg.bal_lower)
                thr = {1'b0, vmin} + cvmb_pkg::THR_W'(BLEED_MID);
            else
                thr = {1'b0, vmin} + cvmb_pkg::THR_W'(BLEED_WIDE);
            for (int k = 0; k < count; k++)
            begin
                r.cell_num = cvmb_pkg::NUM_W'(k);
                r.bleed    = allow && ({1'b0, stored[k]} > thr);
                r.sum      = sum;
                r.vmax     = vmax;
                r.vmin     = vmin;
                r.max_cell = max_cell;
                r.min_cell = min_cell;
                r.ov       = ov;
                r.uv       = uv;
                r.imb      = imb;
                r.solar    = solar;
                r.last_one = (k + 1 == count);
                if (r.bleed)
                    bled++;
                expected_q.push_back(r);
            end
            open_scan();
        endfunction

        function bit field_ok(string fname, logic [31:0] want, logic [31:0] got,
                              bit loud);
            if (got === want)
                return 1'b1;
            if (loud)
                $display("  mismatch on result %0d, %s: expected %0d, got %0d",
                         checked, fname, want, got);
            return 1'b0;
        endfunction

        function void check_result(result_t got);
            result_t want;
            bit      good;
            bit      loud;
            loud = mismatches < 10;
            if (expected_q.size() == 0)
            begin
                if (loud)
                    $display("  unexpected result item, cell_number %0d", got.cell_num);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            good = 1'b1;
            good &= field_ok("cell_number", 32'(want.cell_num), 32'(got.cell_num), loud);
            good &= field_ok("discharge_on", 32'(want.bleed), 32'(got.bleed), loud);
            good &= field_ok("pack_sum", 32'(want.sum), 32'(got.sum), loud);
            good &= field_ok("highest_voltage", 32'(want.vmax), 32'(got.vmax), loud);
            good &= field_ok("lowest_voltage", 32'(want.vmin), 32'(got.vmin), loud);
            good &= field_ok("highest_cell", 32'(want.max_cell), 32'(got.max_cell),
                             loud);
            good &= field_ok("lowest_cell", 32'(want.min_cell), 32'(got.min_cell),
                             loud);
            good &= field_ok("overvoltage_fault", 32'(want.ov), 32'(got.ov), loud);
            good &= field_ok("undervoltage_fault", 32'(want.uv), 32'(got.uv), loud);
            good &= field_ok("imbalance_flag", 32'(want.imb), 32'(got.imb), loud);
            good &= field_ok("open_solar", 32'(want.solar), 32'(got.solar), loud);
            good &= field_ok("last_result", 32'(want.last_one), 32'(got.last_one),
                             loud);
            if (!good)
                mismatches++;
            checked++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [4:0]              paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    cell_valid = 1'b0;
    logic                    cell_ready;
    logic [15:0]             cell_reading = '0;
    logic                    last_cell = 1'b0;
    logic                    balance_request = 1'b0;
    logic signed [18:0]      pack_current_ma = '0;
    logic                    protection_bypassed = 1'b0;
    logic                    result_valid;
    logic                    result_ready = 1'b0;
    logic [5:0]              cell_number;
    logic                    discharge_on;
    logic [21:0]             pack_sum;
    logic [15:0]             highest_voltage;
    logic [15:0]             lowest_voltage;
    logic [6:0]              highest_cell;
    logic [6:0]              lowest_cell;
    logic                    overvoltage_fault;
    logic                    undervoltage_fault;
    logic                    imbalance_flag;
    logic                    open_solar;
    logic                    last_result;

    scan_scoreboard board = new();

    // idling knobs: the sender's is used only by the stimulus process, the
    // receiver's is written with nonblocking assignments
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;

    // long receiver hold-off: the stimulus flips hold_flip, the receiver
    // process notices the change and counts the stretch itself
    logic        hold_flip = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    cell_voltage_monitor_balancer #(
        .CELL_SLOTS(MAX_CELLS)
    ) dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .cell_valid          (cell_valid),
        .cell_ready          (cell_ready),
        .cell_reading        (cell_reading),
        .last_cell           (last_cell),
        .balance_request     (balance_request),
        .pack_current_ma     (pack_current_ma),
        .protection_bypassed (protection_bypassed),
        .result_valid        (result_valid),
        .result_ready        (result_ready),
        .cell_number         (cell_number),
        .discharge_on        (discharge_on),
        .pack_sum            (pack_sum),
        .highest_voltage     (highest_voltage),
        .lowest_voltage      (lowest_voltage),
        .highest_cell        (highest_cell),
        .lowest_cell         (lowest_cell),
        .overvoltage_fault   (overvoltage_fault),
        .undervoltage_fault  (undervoltage_fault),
        .imbalance_flag      (imbalance_flag),
        .open_solar          (open_solar),
        .last_result         (last_result)
    );

    // ------------------------------------------------------------------------
    // result side: random stalls, the long hold-off, and the checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_flip != hold_seen)
        begin
            hold_seen    <= hold_flip;
            hold_left    <= LONG_HOLD;
            result_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // values seen here are the ones from just before the edge
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            board.check_result(result_t'{cell_number, discharge_on, pack_sum,
                                         highest_voltage, lowest_voltage,
                                         highest_cell, lowest_cell,
                                         overvoltage_fault, undervoltage_fault,
                                         imbalance_flag, open_solar, last_result});
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // offer one cell item, with random idle cycles ahead of it, and hand it to
    // the scoreboard once it is taken; valid stays high for a following item
    task automatic send_cell(cell_item_t it);
        if ($urandom_range(99) < send_idle_pct)
        begin
            cell_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        cell_valid          <= 1'b1;
        cell_reading        <= it.raw;
        last_cell           <= it.last;
        balance_request     <= it.request;
        pack_current_ma     <= it.current;
        protection_bypassed <= it.bypass;
        do @(posedge clk); while (!cell_ready);
        board.note_cell(it);
    endtask

    // stop offering and wait until every expected result item is back, then
    // give the closing logic time to go quiet
    task automatic drain_results();
        cell_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write in two phases, setup then access
    task automatic reg_write(cvmb_pkg::reg_idx_t idx, logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_reg(idx, d);
    endtask

    task automatic set_limits(logic [31:0] ov, logic [31:0] uv, logic [31:0] imb,
                              logic [31:0] upper, logic [31:0] lower,
                              logic [31:0] solar, logic [31:0] deb);
        drain_results();
        reg_write(cvmb_pkg::REG_OV_LIMIT, ov);
        reg_write(cvmb_pkg::REG_UV_LIMIT, uv);
        reg_write(cvmb_pkg::REG_IMB_LIMIT, imb);
        reg_write(cvmb_pkg::REG_BAL_UPPER, upper);
        reg_write(cvmb_pkg::REG_BAL_LOWER, lower);
        reg_write(cvmb_pkg::REG_SOLAR, solar);
        reg_write(cvmb_pkg::REG_DEBOUNCE, deb);
    endtask

    function automatic cell_item_t mk_cell(int raw, bit last, bit req, int cur,
                                           bit byp);
        cell_item_t it;
        it.raw     = cvmb_pkg::CELL_W'(raw);
        it.last    = last;
        it.request = req;
        it.current = cvmb_pkg::CUR_W'(cur);
        it.bypass  = byp;
        return it;
    endfunction

    // raw reading that lands at the given level after the offset
    function automatic logic [cvmb_pkg::CELL_W-1:0] raw_for(int level);
        int r;
        r = level - READING_OFFSET;
        if (r < 0)
            r = 0;
        if (r > 65535)
            r = 65535;
        return cvmb_pkg::CELL_W'(r);
    endfunction

    // pack current: near the balancing cap, charging, any value, or discharging
    function automatic int pick_current();
        case ($urandom_range(3))
            0: return CURRENT_CAP_MA - 10 + int'($urandom_range(20));
            1: return -int'($urandom_range(262144, 1));
            2: return int'($urandom_range(262143)) - int'($urandom_range(262144));
            default: return int'($urandom_range(CURRENT_CAP_MA));
        endcase
    endfunction

    // scan level near one of the active thresholds, so that bands, faults and
    // flags switch often; sometimes anywhere or at the saturation point
    function automatic int pick_level();
        int lvl;
        case ($urandom_range(7))
            0: lvl = board.cfg.ov_limit;
            1: lvl = board.cfg.uv_limit;
            2: lvl = board.cfg.bal_upper;
            3: lvl = board.cfg.bal_lower;
            4: lvl = board.cfg.solar_limit;
            5: lvl = 65535;
            default: lvl = $urandom_range(65535);
        endcase
        lvl = lvl + int'($urandom_range(300)) - 150;
        return (lvl < 0) ? 0 : lvl;
    endfunction

    // a whole scan of n cells; spread 0 gives ties among all cells not drawn at random
    task automatic send_scan(int n, int level, int spread);
        cell_item_t it;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(19) == 0)
                it.raw = cvmb_pkg::CELL_W'($urandom());
            else
                it.raw = raw_for(level + int'($urandom_range(spread)));
            it.last    = (i == n - 1);
            it.request = ($urandom_range(3) != 0);
            it.current = cvmb_pkg::CUR_W'(pick_current());
            it.bypass  = 1'($urandom_range(1));
            send_cell(it);
        end
    endtask

    // well-formed scans with random content; most are short, a few run up to the
    // store depth and a few overrun it
    task automatic random_scans(int items, bit pause_midway);
        int sent;
        int n;
        int spread;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < items)
        begin
            case ($urandom_range(19))
                0:       n = $urandom_range(MAX_CELLS + 8, MAX_CELLS + 1);
                1, 2, 3: n = $urandom_range(MAX_CELLS, 9);
                default: n = $urandom_range(8, 1);
            endcase
            case ($urandom_range(3))
                0: spread = 0;
                1: spread = 30;
                2: spread = 160;
                default: spread = 2000;
            endcase
            send_scan(n, pick_level(), spread);
            sent += n;
            // sender holds back until the block has handed everything over
            if (pause_midway && !paused && sent >= items / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        board.power_on();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed scans at the reset register values, no idling
        // extremes of the reading, offset saturation, tie on the max
        send_cell(mk_cell(0, 0, 0, 0, 1));
        send_cell(mk_cell(65535, 0, 0, 0, 1));
        send_cell(mk_cell(65535, 1, 1, -262144, 0));
        // narrow band: min at the upper band edge, one cell just over min+20,
        // one exactly at it, tie on the min
        send_cell(mk_cell(41000, 0, 0, 0, 0));
        send_cell(mk_cell(41021, 0, 0, 0, 0));
        send_cell(mk_cell(41000, 0, 0, 0, 0));
        send_cell(mk_cell(41020, 0, 0, 0, 0));
        send_cell(mk_cell(41050, 1, 1, CURRENT_CAP_MA, 1));
        // middle band at its lower edge, current exactly at the cap
        send_cell(mk_cell(39500, 0, 0, 0, 0));
        send_cell(mk_cell(39550, 0, 0, 0, 0));
        send_cell(mk_cell(39551, 1, 1, CURRENT_CAP_MA, 0));
        // wide band, current one over the cap: balancing off
        send_cell(mk_cell(39000, 0, 0, 0, 0));
        send_cell(mk_cell(39101, 0, 0, 0, 0));
        send_cell(mk_cell(39100, 1, 1, CURRENT_CAP_MA + 1, 0));
        // single cell, request off, largest current
        send_cell(mk_cell(65535, 1, 0, 262143, 1));
        // min exactly at the under-voltage limit
        send_cell(mk_cell(24500, 1, 1, -1, 0));
        // max exactly at the over-voltage limit, min at the solar limit
        send_cell(mk_cell(42000, 0, 0, 0, 0));
        send_cell(mk_cell(40500, 1, 1, 0, 0));

        // mid settings, sender idle most cycles, one pause to drain midway
        set_limits(41000, 38000, 150, 40500, 39000, 40000, 2);
        send_idle_pct = 66;
        send_scan(MAX_CELLS + 5, 40000, 200);
        random_scans(20, 1'b1);

        // all thresholds at zero, debounce zero; receiver stalls most cycles
        set_limits(0, 0, 0, 0, 0, 0, 0);
        send_idle_pct = 0;
        stall_pct    <= 66;
        random_scans(20, 1'b0);

        // all ones with junk in the upper data bits; both sides idle a little,
        // and the receiver holds off long enough that three short scans fill
        // both banks and the input backs up
        set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_idle_pct = 10;
        stall_pct    <= 10;
        hold_flip    <= ~hold_flip;
        for (int i = 0; i < 3; i++)
            send_scan(3, pick_level(), 160);
        random_scans(25, 1'b0);

        // every scan faulty both ways: the fault flags stay off until the
        // streaks reach the debounce count, then stay on
        set_limits(0, 65535, 1000, 41500, 40000, 41000, 12);
        send_idle_pct = 0;
        stall_pct    <= 0;
        for (int i = 0; i < 20; i++)
            send_scan(1, $urandom_range(66035), 0);

        // short debounce around mid thresholds: streaks build and clear
        set_limits(40000, 30000, 500, 35000, 30000, 38000, 3);
        send_idle_pct = 10;
        stall_pct    <= 10;
        random_scans(20, 1'b0);

        drain_results();
        $display("covered %0d scans from %0d cell items over six register settings",
                 board.scans, board.cells_in);
        $display("%0d result items checked, %0d bled, %0d mismatching",
                 board.checked, board.bled, board.mismatches);
        if (board.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timeout with %0d result items outstanding", board.pending());
        $display("status: fail");
        $finish;
    end

endmodule
